// ===== rtl/core/kdlp_pkg.sv =====
// Shared types and constants for the key debounce and long-press block.
// Used by every module under rtl/core; depends on nothing.

package kdlp_pkg;

    localparam int KEY_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT_LIMIT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] HOLD_LIMIT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2,
        EV_LONG = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] long_press_ticks;
        logic [CFG_DATA_W-1:0] hold_count_limit;
    } cfg_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [KEY_W-1:0] keys;
    } event_t;

endpackage

// ===== rtl/core/key_debounce_long_press.sv =====
// Key debounce with down, short-release and long-press events (top level).
// An accepted item is registered in the input stage; its event is then registered in the output stage for m_*.
// Throughput: one item per cycle while m_tready is high; a full input stage and output stage hold two items.
// The debounce state and event logic sit between the input and output register.
// Reset clears the debounce state and both stages and loads the register defaults.
// Depends on kdlp_pkg, kdlp_cfg_regs and kdlp_scan_logic.

module key_debounce_long_press
#(
    parameter int NUM_KEYS    = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] key_pins
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] event_keys
    output logic [1:0]                      m_tuser,   // [1:0] event_kind
    input  logic                            cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    kdlp_pkg::cfg_t   cfg;
    kdlp_pkg::event_t result;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [kdlp_pkg::KEY_W-1:0] in_pins_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    kdlp_pkg::event_t           out_event_reg;

    logic out_load;
    logic in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    kdlp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kdlp_scan_logic
    #(
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (out_load),
        .key_pins (in_pins_reg),
        .cfg      (cfg),
        .result   (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_pins_reg <= s_tdata;
        end
        if (out_load)
        begin
            out_event_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_event_reg.keys;
    assign m_tuser  = out_event_reg.kind;

endmodule

// ===== rtl/core/kdlp_cfg_regs.sv =====
// Configuration registers: long-press threshold and hold counter limit.
// Depends on kdlp_pkg.

module kdlp_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output kdlp_pkg::cfg_t                  cfg
);

    kdlp_pkg::cfg_t cfg_reg;
    kdlp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                kdlp_pkg::REG_LONG_PRESS_TICKS: cfg_next.long_press_ticks = cfg_wdata;
                kdlp_pkg::REG_HOLD_COUNT_LIMIT: cfg_next.hold_count_limit = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= kdlp_pkg::LONG_PRESS_RESET;
            cfg_reg.hold_count_limit <= kdlp_pkg::HOLD_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/kdlp_scan_logic.sv =====
// Per-tick debounce state (previous scan, stable mask, hold counter) and event selection.
// Depends on kdlp_pkg.

module kdlp_scan_logic
#(
    parameter int NUM_KEYS    = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [kdlp_pkg::KEY_W-1:0]  key_pins,
    input  kdlp_pkg::cfg_t              cfg,
    output kdlp_pkg::event_t            result
);

    localparam int CMP_W = (COUNT_WIDTH > kdlp_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                                : kdlp_pkg::CFG_DATA_W;
    localparam logic [kdlp_pkg::KEY_W-1:0] KEY_MASK =
        (NUM_KEYS >= kdlp_pkg::KEY_W) ? {kdlp_pkg::KEY_W{1'b1}}
                                      : kdlp_pkg::KEY_W'((1 << NUM_KEYS) - 1);

    logic [kdlp_pkg::KEY_W-1:0] prev_scan_reg;
    logic [kdlp_pkg::KEY_W-1:0] prev_scan_next;
    logic [kdlp_pkg::KEY_W-1:0] stable_reg;
    logic [kdlp_pkg::KEY_W-1:0] stable_next;
    logic [COUNT_WIDTH-1:0]     hold_reg;
    logic [COUNT_WIDTH-1:0]     hold_next;

    logic [kdlp_pkg::KEY_W-1:0] pressed;
    logic [COUNT_WIDTH-1:0]     hold_inc;
    logic [CMP_W-1:0]           hold_ext;
    logic [CMP_W-1:0]           hold_inc_ext;
    logic [CMP_W-1:0]           lpt_ext;
    logic [CMP_W-1:0]           limit_ext;

    assign pressed      = ~key_pins & KEY_MASK;
    assign hold_inc     = hold_reg + 1'b1;
    assign hold_ext     = CMP_W'(hold_reg);
    assign hold_inc_ext = CMP_W'(hold_inc);
    assign lpt_ext      = CMP_W'(cfg.long_press_ticks);
    assign limit_ext    = CMP_W'(cfg.hold_count_limit);

    always_comb
    begin
        prev_scan_next = pressed;
        stable_next    = stable_reg;
        hold_next      = hold_reg;
        result.kind    = kdlp_pkg::EV_NONE;
        result.keys    = '0;
        if (pressed == prev_scan_reg)
        begin
            stable_next = pressed;
            if (pressed != stable_reg)
            begin
                if (pressed != '0)
                begin
                    result.kind = kdlp_pkg::EV_DOWN;
                    result.keys = pressed;
                    hold_next   = '0;
                end
                else if (hold_ext < lpt_ext)
                begin
                    result.kind = kdlp_pkg::EV_UP;
                    result.keys = stable_reg;
                end
            end
            else if (pressed != '0 && hold_ext < limit_ext && hold_reg != '1)
            begin
                hold_next = hold_inc;
                if (hold_inc_ext == lpt_ext)
                begin
                    result.kind = kdlp_pkg::EV_LONG;
                    result.keys = pressed;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_scan_reg <= '0;
            stable_reg    <= '0;
            hold_reg      <= '0;
        end
        else if (step_en)
        begin
            prev_scan_reg <= prev_scan_next;
            stable_reg    <= stable_next;
            hold_reg      <= hold_next;
        end
    end

endmodule
